@@ rtl/core/sle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    typedef enum logic [3:0] {
        FN_PUSH_BACK   = 4'd0,
        FN_POP_BACK    = 4'd1,
        FN_PUSH_FRONT  = 4'd2,
        FN_POP_FRONT   = 4'd3,
        FN_INSERT      = 4'd4,
        FN_ERASE       = 4'd5,
        FN_FIND        = 4'd6,
        FN_SORT        = 4'd7,
        FN_BINARY_FIND = 4'd8,
        FN_DUMP        = 4'd9
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_OPEN  = 2'd1,
        CELL_CLOSE = 2'd2,
        CELL_SORT  = 2'd3
    } cell_op_t;

    // broadcast to every cell in the row
    typedef struct packed {
        cell_op_t    op;
        logic        phase;
        logic [4:0]  at;
        logic [4:0]  count;
    } cell_ctrl_t;

endpackage

@@ rtl/core/sequential_list_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_unit
// Packed list of signed words held in a row of cells, with list commands.
// ----------------------------------------------------------------------------
// usage
//   command channel: cmd_valid/cmd_stall with func, position, value. one
//   command is taken at a time; cmd_stall stays high until its last result
//   word has been loaded into the result register.
//   result channel: rsp_valid/rsp_stall with status, found, index, element,
//   count, last. a word waits in the result register while rsp_stall is high;
//   the engine holds its next result word until the register is free again.
//   cfg_we/cfg_data write capacity_limit; write it only while the engine is idle, the block does not enforce this.
// pace of each command
//   push, pop, insert, erase: cells from the position on shift at once; unused codes only answer
//   sort: one odd-even transposition phase per cycle
//   find: one slot compared per cycle
//   binary find: one probe per cycle
//   dump: one word per cycle while the result register is free
//   the shared slot read mux sets the search and dump pace.
// reset
//   count clears to zero and capacity_limit to 16; slot contents are left.
// ----------------------------------------------------------------------------
module sequential_list_engine_unit #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [4:0]                    cfg_data,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [3:0]                    func,
    input  logic [4:0]                    position,
    input  logic signed [DATA_WIDTH-1:0]  value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [3:0]                    index,
    output logic signed [DATA_WIDTH-1:0]  element,
    output logic [4:0]                    count,
    output logic                          last
);
    import sle_pkg::*;

    localparam int NCELL = (CAPACITY < 16) ? CAPACITY : 16;
    localparam int IW    = $clog2(NCELL);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_SORT = 7'b0000100,
        S_DONE = 7'b0001000,
        S_SCAN = 7'b0010000,
        S_BIN  = 7'b0100000,
        S_DUMP = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [4:0]                    limit_reg;
    logic [4:0]                    count_reg, count_next;
    logic [3:0]                    func_reg;
    logic [4:0]                    pos_reg;
    logic signed [DATA_WIDTH-1:0]  val_reg;
    logic [IW-1:0]                 i_reg, i_next;
    logic [4:0]                    lo_reg, lo_next;
    logic [4:0]                    hi_reg, hi_next;

    logic                          rsp_valid_reg;
    logic [1:0]                    status_reg;
    logic                          found_reg;
    logic [3:0]                    index_reg;
    logic signed [DATA_WIDTH-1:0]  element_reg;
    logic [4:0]                    count_out_reg;
    logic                          last_reg;

    cell_ctrl_t                    ctrl;
    logic signed [DATA_WIDTH-1:0]  cell_elem [NCELL];
    logic signed [DATA_WIDTH-1:0]  rd_elem;
    logic [IW-1:0]                 rd_idx;
    logic [4:0]                    lim;
    logic [4:0]                    at_ins, at_del;
    logic [5:0]                    mid_sum;
    logic [4:0]                    mid;
    logic                          out_free;
    logic                          emit;
    status_t                       em_status;
    logic                          em_found;
    logic [IW-1:0]                 em_index;
    logic signed [DATA_WIDTH-1:0]  em_elem;
    logic                          em_last;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] lft, rgt;
            if (g == 0)
            begin : g_first
                assign lft = cell_elem[g];
            end
            else
            begin : g_mid_l
                assign lft = cell_elem[g-1];
            end
            if (g == NCELL - 1)
            begin : g_end
                assign rgt = cell_elem[g];
            end
            else
            begin : g_mid_r
                assign rgt = cell_elem[g+1];
            end
            sle_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX        (g)
            ) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .value (val_reg),
                .left  (lft),
                .right (rgt),
                .elem  (cell_elem[g])
            );
        end
    endgenerate

    assign lim      = (limit_reg > 5'(NCELL)) ? 5'(NCELL) : limit_reg;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[5:1];
    assign rd_idx   = (state_reg == S_BIN) ? mid[IW-1:0] : i_reg;
    assign rd_elem  = cell_elem[rd_idx];

    always_comb
    begin
        at_ins = pos_reg;
        at_del = pos_reg;
        if (func_reg == FN_PUSH_BACK)
            at_ins = count_reg;
        else if (func_reg == FN_PUSH_FRONT)
            at_ins = 5'd0;
        if (func_reg == FN_POP_BACK)
            at_del = count_reg - 5'd1;
        else if (func_reg == FN_POP_FRONT)
            at_del = 5'd0;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        ctrl.op    = CELL_HOLD;
        ctrl.phase = lo_reg[0];
        ctrl.at    = 5'd0;
        ctrl.count = count_reg;
        emit       = 1'b0;
        em_status  = ST_OK;
        em_found   = 1'b0;
        em_index   = '0;
        em_elem    = '0;
        em_last    = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (func_reg)
                    FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (count_reg >= lim)
                                em_status = ST_FULL;
                            else if (at_ins > count_reg)
                                em_status = ST_RANGE;
                            else
                            begin
                                ctrl.op    = CELL_OPEN;
                                ctrl.at    = at_ins;
                                count_next = count_reg + 5'd1;
                            end
                        end
                    end
                    FN_POP_BACK, FN_POP_FRONT, FN_ERASE:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (count_reg == 5'd0)
                                em_status = ST_EMPTY;
                            else if (at_del >= count_reg)
                                em_status = ST_RANGE;
                            else
                            begin
                                ctrl.op    = CELL_CLOSE;
                                ctrl.at    = at_del;
                                count_next = count_reg - 5'd1;
                            end
                        end
                    end
                    FN_FIND, FN_DUMP:
                    begin
                        i_next = '0;
                        if (count_reg != 5'd0)
                            state_next = (func_reg == FN_FIND) ? S_SCAN : S_DUMP;
                        else if (out_free)
                        begin
                            emit       = 1'b1;
                            em_status  = ST_EMPTY;
                            state_next = S_IDLE;
                        end
                    end
                    FN_BINARY_FIND:
                    begin
                        lo_next = 5'd0;
                        hi_next = count_reg;
                        if (count_reg != 5'd0)
                            state_next = S_BIN;
                        else if (out_free)
                        begin
                            emit       = 1'b1;
                            em_status  = ST_EMPTY;
                            state_next = S_IDLE;
                        end
                    end
                    FN_SORT:
                    begin
                        // lo doubles as the phase counter during sort
                        lo_next    = 5'd0;
                        state_next = S_SORT;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_SORT:
            begin
                if (lo_reg >= count_reg)
                    state_next = S_DONE;
                else
                begin
                    ctrl.op = CELL_SORT;
                    lo_next = lo_reg + 5'd1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (rd_elem == val_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        em_found   = 1'b1;
                        em_index   = i_reg;
                        state_next = S_IDLE;
                    end
                end
                else if ((5'(i_reg) + 5'd1) >= count_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                    i_next = i_reg + 1'b1;
            end
            S_BIN:
            begin
                if (lo_reg >= hi_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (rd_elem < val_reg)
                    lo_next = mid + 5'd1;
                else if (rd_elem > val_reg)
                    hi_next = mid;
                else if (out_free)
                begin
                    emit       = 1'b1;
                    em_found   = 1'b1;
                    em_index   = mid[IW-1:0];
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    em_index = i_reg;
                    em_elem  = rd_elem;
                    em_last  = (5'(i_reg) + 5'd1) >= count_reg;
                    i_next   = i_reg + 1'b1;
                    if (em_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= 5'd16;
            count_reg     <= 5'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
                limit_reg <= cfg_data;
            if (emit)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg  <= i_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (state_reg == S_IDLE)
        begin
            func_reg <= func;
            pos_reg  <= position;
            val_reg  <= value;
        end
        if (emit)
        begin
            status_reg    <= em_status;
            found_reg     <= em_found;
            index_reg     <= 4'(em_index);
            element_reg   <= em_elem;
            count_out_reg <= count_next;
            last_reg      <= em_last;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign index     = index_reg;
    assign element   = element_reg;
    assign count     = count_out_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 5'(NCELL))
        else $error("element count above cell count");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> $stable(element) && $stable(status))
        else $error("result overwritten while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg != S_IDLE))
        else $error("engine idle right after taking a command");
`endif

endmodule

@@ rtl/core/sle_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds an element, shifts toward either neighbor and does one
// compare-exchange step of an odd-even transposition sort.
// ----------------------------------------------------------------------------
module sle_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                          clk,
    input  sle_pkg::cell_ctrl_t           ctrl,
    input  logic signed [DATA_WIDTH-1:0]  value,
    input  logic signed [DATA_WIDTH-1:0]  left,
    input  logic signed [DATA_WIDTH-1:0]  right,
    output logic signed [DATA_WIDTH-1:0]  elem
);
    import sle_pkg::*;

    localparam logic [4:0] ME = IDX[4:0];

    logic signed [DATA_WIDTH-1:0] elem_reg;
    logic signed [DATA_WIDTH-1:0] elem_next;
    logic                         pair_right;
    logic                         pair_left;

    // pair with right neighbor when our parity matches the phase and it holds a list element
    assign pair_right = (ME[0] == ctrl.phase) && ((ME + 5'd1) < ctrl.count);
    assign pair_left  = (ME != 5'd0) && (ME[0] != ctrl.phase) && (ME < ctrl.count);

    always_comb
    begin
        elem_next = elem_reg;
        unique case (ctrl.op)
            CELL_OPEN:
            begin
                if (ME > ctrl.at)
                    elem_next = left;
                else if (ME == ctrl.at)
                    elem_next = value;
            end
            CELL_CLOSE:
            begin
                if (ME >= ctrl.at)
                    elem_next = right;
            end
            CELL_SORT:
            begin
                if (pair_right && (right < elem_reg))
                    elem_next = right;
                else if (pair_left && (elem_reg < left))
                    elem_next = left;
            end
            default:
            begin
                elem_next = elem_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    assign elem = elem_reg;

endmodule
